### rtl/core/pes_pkg.sv
// shared types, constants and microcode table of the prefix expression evaluator
`timescale 1ns / 1ps

package pes_pkg;

   // stack geometry and word widths
   localparam int STACK_DEPTH = 64;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int DATA_W      = 32;
   localparam int OPND_W      = 31;
   localparam int CMD_W       = 3;
   localparam int STATUS_W    = 3;
   localparam int DIV_CNT_W   = $clog2(DATA_W);

   // token commands
   typedef logic [CMD_W-1:0] cmd_type;
   localparam cmd_type CMD_PUSH = 3'd0;
   localparam cmd_type CMD_ADD  = 3'd1;
   localparam cmd_type CMD_SUB  = 3'd2;
   localparam cmd_type CMD_MUL  = 3'd3;
   localparam cmd_type CMD_DIV  = 3'd4;

   // result status codes
   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type ST_OK    = 3'd0;
   localparam status_type ST_DIV0  = 3'd1;
   localparam status_type ST_UNDER = 3'd2;
   localparam status_type ST_OVER  = 3'd3;
   localparam status_type ST_LEFT  = 3'd4;

   // datapath actions driven by one control word
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_WAIT,
      ACT_PUSH,
      ACT_UNDER,
      ACT_READ,
      ACT_ALU,
      ACT_DIV0,
      ACT_DIVSTART,
      ACT_DIVWB,
      ACT_FINISH
   } act_type;

   // jump conditions of the sequencer
   typedef enum logic [2:0] {
      C_ALWAYS,
      C_NO_ACCEPT,
      C_DISPATCH,
      C_IS_DIV,
      C_RIGHT_ZERO,
      C_DIV_BUSY,
      C_OUT_BUSY
   } cond_type;

   // microcode addresses
   typedef logic [3:0] step_type;
   localparam step_type U_IDLE     = 4'd0;
   localparam step_type U_DISPATCH = 4'd1;
   localparam step_type U_PUSH     = 4'd2;
   localparam step_type U_UNDER    = 4'd3;
   localparam step_type U_READ     = 4'd4;
   localparam step_type U_EXEC     = 4'd5;
   localparam step_type U_ALU      = 4'd6;
   localparam step_type U_DIVCHK   = 4'd7;
   localparam step_type U_DIVGO    = 4'd8;
   localparam step_type U_DIVWAIT  = 4'd9;
   localparam step_type U_DIVWB    = 4'd10;
   localparam step_type U_DIVZ     = 4'd11;
   localparam step_type U_FIN      = 4'd12;

   // one control word: action, condition, target when true, target when false
   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type jump_step;
      step_type fall_step;
   } ucode_type;

   // status flags from the datapath to the sequencer
   typedef struct packed {
      logic accept;
      logic is_push;
      logic is_op;
      logic short_stack;
      logic is_div;
      logic right_zero;
      logic div_busy;
      logic out_busy;
   } seq_flags_type;

   // microcode program
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      unique case (step)
         U_IDLE:     word = '{ACT_WAIT,     C_NO_ACCEPT,  U_IDLE,    U_DISPATCH};
         U_DISPATCH: word = '{ACT_NONE,     C_DISPATCH,   U_FIN,     U_FIN};
         U_PUSH:     word = '{ACT_PUSH,     C_ALWAYS,     U_FIN,     U_FIN};
         U_UNDER:    word = '{ACT_UNDER,    C_ALWAYS,     U_FIN,     U_FIN};
         U_READ:     word = '{ACT_READ,     C_ALWAYS,     U_EXEC,    U_EXEC};
         U_EXEC:     word = '{ACT_NONE,     C_IS_DIV,     U_DIVCHK,  U_ALU};
         U_ALU:      word = '{ACT_ALU,      C_ALWAYS,     U_FIN,     U_FIN};
         U_DIVCHK:   word = '{ACT_NONE,     C_RIGHT_ZERO, U_DIVZ,    U_DIVGO};
         U_DIVGO:    word = '{ACT_DIVSTART, C_ALWAYS,     U_DIVWAIT, U_DIVWAIT};
         U_DIVWAIT:  word = '{ACT_NONE,     C_DIV_BUSY,   U_DIVWAIT, U_DIVWB};
         U_DIVWB:    word = '{ACT_DIVWB,    C_ALWAYS,     U_FIN,     U_FIN};
         U_DIVZ:     word = '{ACT_DIV0,     C_ALWAYS,     U_FIN,     U_FIN};
         U_FIN:      word = '{ACT_FINISH,   C_OUT_BUSY,   U_FIN,     U_IDLE};
         default:    word = '{ACT_NONE,     C_ALWAYS,     U_IDLE,    U_IDLE};
      endcase
      return word;
   endfunction

endpackage

### rtl/core/pes_if.sv
// token and result channel interfaces of the prefix expression evaluator
`timescale 1ns / 1ps

// token channel
interface pes_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [30:0] operand;
   logic        last;

   modport source (output valid, output cmd, output operand, output last, input ready);
   modport sink   (input valid, input cmd, input operand, input last, output ready);
endinterface

// result channel
interface pes_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic [2:0]         status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

### rtl/core/prefix_expression_stack_evaluator.sv
// top level: value stack datapath under a microcoded sequencer
// Each token runs its own microcode path before the token port is ready again; a divide also waits on the divider.
// The result word of a last token is valid the cycle after its final step and is held
// in an output register; the token port takes one token at a time.
// Reset is synchronous: clears sequencer, depth, error and output valid; stack memory is not.
`timescale 1ns / 1ps

module prefix_expression_stack_evaluator import pes_pkg::*; (
   input logic      clock,
   input logic      reset,
   pes_req_if.sink  req,
   pes_rsp_if.source rsp
);

   act_type       act;
   seq_flags_type flags;
   logic          accept;
   logic          out_busy;
   logic          full;
   logic          div_busy;
   logic [DATA_W-1:0] div_quo;

   // token registers
   cmd_type           cmd_ff, cmd_in;
   logic [OPND_W-1:0] opnd_ff, opnd_in;
   logic              last_ff, last_in;

   // stack state
   logic [DATA_W-1:0]  tos_ff, tos_in;
   logic [DATA_W-1:0]  rd_ff;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   status_type         err_ff, err_in;
   logic [DEPTH_W-1:0] depth_m1;
   logic [DEPTH_W-1:0] depth_m2;
   logic [DATA_W-1:0]  stack_mem [STACK_DEPTH];
   logic [DATA_W-1:0]  alu_res;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   status_type         rsp_status_ff, rsp_status_in;

   function automatic status_type note_err(input status_type cur, input status_type code);
      return (cur == ST_OK) ? code : cur;
   endfunction

   assign req.ready = (act == ACT_WAIT);
   assign accept    = req.valid && req.ready;
   assign out_busy  = last_ff && rsp_valid_ff && !rsp.ready;
   assign full      = (depth_ff == DEPTH_W'(STACK_DEPTH));
   assign depth_m1  = depth_ff - DEPTH_W'(1);
   assign depth_m2  = depth_ff - DEPTH_W'(2);

   // flags to the sequencer
   always_comb begin
      flags.accept      = accept;
      flags.is_push     = (cmd_ff == CMD_PUSH);
      flags.is_op       = (cmd_ff >= CMD_ADD) && (cmd_ff <= CMD_DIV);
      flags.short_stack = (depth_ff < DEPTH_W'(2));
      flags.is_div      = (cmd_ff == CMD_DIV);
      flags.right_zero  = (rd_ff == '0);
      flags.div_busy    = div_busy;
      flags.out_busy    = out_busy;
   end

   pes_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .act   (act)
   );

   pes_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (act == ACT_DIVSTART),
      .dividend (tos_ff),
      .divisor  (rd_ff),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // add, subtract, multiply; left is top of stack, right the entry below
   always_comb begin
      case (cmd_ff)
         CMD_ADD: alu_res = tos_ff + rd_ff;
         CMD_SUB: alu_res = tos_ff - rd_ff;
         default: alu_res = tos_ff * rd_ff;
      endcase
   end

   // datapath actions
   always_comb begin
      cmd_in        = cmd_ff;
      opnd_in       = opnd_ff;
      last_in       = last_ff;
      tos_in        = tos_ff;
      depth_in      = depth_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      unique case (act)
         ACT_WAIT: begin
            if (accept) begin
               cmd_in  = req.cmd;
               opnd_in = req.operand;
               last_in = req.last;
            end
         end
         ACT_PUSH: begin
            if (full) begin
               err_in = note_err(err_ff, ST_OVER);
            end else begin
               tos_in   = {1'b0, opnd_ff};
               depth_in = depth_ff + DEPTH_W'(1);
            end
         end
         ACT_UNDER: begin
            err_in = note_err(err_ff, ST_UNDER);
         end
         ACT_ALU: begin
            tos_in   = alu_res;
            depth_in = depth_m1;
         end
         ACT_DIV0: begin
            err_in = note_err(err_ff, ST_DIV0);
         end
         ACT_DIVWB: begin
            tos_in   = div_quo;
            depth_in = depth_m1;
         end
         ACT_FINISH: begin
            if (last_ff && !out_busy) begin
               rsp_valid_in = 1'b1;
               if (depth_ff == '0) begin
                  rsp_value_in  = '0;
                  rsp_status_in = note_err(err_ff, ST_UNDER);
               end else begin
                  rsp_value_in  = $signed(tos_ff);
                  rsp_status_in = (depth_ff > DEPTH_W'(1)) ? note_err(err_ff, ST_LEFT)
                                                           : err_ff;
               end
               depth_in = '0;
               err_in   = ST_OK;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      opnd_ff       <= opnd_in;
      last_ff       <= last_in;
      tos_ff        <= tos_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // stack memory below the top register: one write, one registered read
   always_ff @(posedge clock) begin
      if (act == ACT_PUSH && !full && depth_ff != '0) begin
         stack_mem[depth_m1[IDX_W-1:0]] <= tos_ff;
      end
      if (act == ACT_READ) begin
         rd_ff <= stack_mem[depth_m2[IDX_W-1:0]];
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.value  = rsp_value_ff;
   assign rsp.status = rsp_status_ff;

   // push onto a full stack keeps the depth and leaves an error
   a_full_push: assert property (@(posedge clock) disable iff (reset)
      (act == ACT_PUSH && full) |=> (full && err_ff != ST_OK))
      else $error("push onto full stack changed depth or lost error");

   // tokens are taken only with the divider idle
   a_ready_div: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !div_busy)
      else $error("token port ready while divider busy");

   // a new result leaves the stack emptied and the error cleared
   a_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (depth_ff == '0 && err_ff == ST_OK))
      else $error("stack not cleared after result");

   // an arithmetic step pops exactly one entry
   a_alu_pop: assert property (@(posedge clock) disable iff (reset)
      (act == ACT_ALU) |=> (depth_ff == $past(depth_ff) - DEPTH_W'(1)))
      else $error("arithmetic step did not pop one entry");

endmodule

### rtl/core/pes_divider.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
`timescale 1ns / 1ps

module pes_divider import pes_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              busy,
   output logic [DATA_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    dvs_ff, dvs_in;
   logic                 neg_ff, neg_in;
   logic [DATA_W:0]      trial;
   logic                 dend_neg;
   logic                 dvs_neg;

   assign dend_neg = dividend[DATA_W-1];
   assign dvs_neg  = divisor[DATA_W-1];
   assign trial    = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, dvs_ff};

   // restoring step on magnitudes
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dend_neg ? (DATA_W'(0) - dividend) : dividend;
         dvs_in  = dvs_neg ? (DATA_W'(0) - divisor) : divisor;
         neg_in  = dend_neg ^ dvs_neg;
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;

endmodule

### rtl/core/pes_sequencer.sv
// microcode sequencer: step counter, control table lookup and conditional jumps
`timescale 1ns / 1ps

module pes_sequencer import pes_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  seq_flags_type flags,
   output act_type       act
);

   step_type  step_ff, step_in;
   ucode_type word;
   logic      cond_hit;
   step_type  dispatch_step;

   assign word = ucode_rom(step_ff);
   assign act  = word.act;

   // token dispatch
   always_comb begin
      if (flags.is_push) begin
         dispatch_step = U_PUSH;
      end else if (flags.is_op && flags.short_stack) begin
         dispatch_step = U_UNDER;
      end else if (flags.is_op) begin
         dispatch_step = U_READ;
      end else begin
         dispatch_step = U_FIN;
      end
   end

   // condition select
   always_comb begin
      unique case (word.cond)
         C_ALWAYS:     cond_hit = 1'b1;
         C_NO_ACCEPT:  cond_hit = !flags.accept;
         C_IS_DIV:     cond_hit = flags.is_div;
         C_RIGHT_ZERO: cond_hit = flags.right_zero;
         C_DIV_BUSY:   cond_hit = flags.div_busy;
         C_OUT_BUSY:   cond_hit = flags.out_busy;
         default:      cond_hit = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      if (word.cond == C_DISPATCH) begin
         step_in = dispatch_step;
      end else if (cond_hit) begin
         step_in = word.jump_step;
      end else begin
         step_in = word.fall_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= U_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### tb/prefix_expression_stack_evaluator_test.sv
// self-checking testbench of the prefix expression evaluator: directed and random token streams
`timescale 1ns / 1ps

module prefix_expression_stack_evaluator_test import pes_pkg::*;;

   // command codes the block treats as no-ops
   localparam cmd_type CMD_SPARE5 = 3'd5;
   localparam cmd_type CMD_SPARE6 = 3'd6;
   localparam cmd_type CMD_SPARE7 = 3'd7;

   localparam int LIMIT_CYCLES  = 400000;
   localparam int SETTLE_CYCLES = 60;
   localparam int MAX_REPORTS   = 10;

   typedef struct {
      logic [31:0] value;
      status_type  status;
   } eval_result_type;

   logic clock;
   logic reset;

   pes_req_if req_ch();
   pes_rsp_if rsp_ch();

   prefix_expression_stack_evaluator u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // clock, 2 ns period
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [31:0]     calc_stack [STACK_DEPTH];
   int unsigned     calc_depth = 0;
   status_type      calc_error = ST_OK;
   eval_result_type predicted_results [$];

   // run bookkeeping
   int unsigned cycle_count     = 0;
   int unsigned tokens_sent     = 0;
   int unsigned results_checked = 0;
   int unsigned mismatch_count  = 0;
   int unsigned send_idle_pct   = 0;
   int unsigned recv_stall_pct  = 0;
   int unsigned hold_cycles     = 0;

   // keep only the first error of an expression
   function automatic void note_error(input status_type code);
      if (calc_error == ST_OK)
         calc_error = code;
   endfunction

   // signed divide, truncating toward zero; most negative by -1 wraps
   function automatic logic [31:0] divide_trunc(input logic [31:0] lhs, input logic [31:0] rhs);
      logic [31:0] mag_l, mag_r, quot;
      mag_l = lhs[31] ? (32'd0 - lhs) : lhs;
      mag_r = rhs[31] ? (32'd0 - rhs) : rhs;
      quot  = mag_l / mag_r;
      return (lhs[31] != rhs[31]) ? (32'd0 - quot) : quot;
   endfunction

   // advance the predicted stack by one accepted token
   task automatic evaluate_token(input cmd_type cmd, input logic [30:0] opnd, input logic lst);
      logic [31:0]     lhs, rhs, res;
      bit              ok;
      eval_result_type outcome;
      ok  = 1'b1;
      res = '0;
      case (cmd) inside
         CMD_PUSH: begin
            if (calc_depth >= STACK_DEPTH) begin
               note_error(ST_OVER);
            end else begin
               calc_stack[calc_depth] = {1'b0, opnd};
               calc_depth++;
            end
         end
         [CMD_ADD:CMD_DIV]: begin
            if (calc_depth < 2) begin
               note_error(ST_UNDER);
            end else begin
               lhs = calc_stack[calc_depth-1];
               rhs = calc_stack[calc_depth-2];
               case (cmd)
                  CMD_ADD: res = lhs + rhs;
                  CMD_SUB: res = lhs - rhs;
                  CMD_MUL: res = lhs * rhs;
                  default: begin
                     if (rhs == 32'd0) begin
                        note_error(ST_DIV0);
                        ok = 1'b0;
                     end else begin
                        res = divide_trunc(lhs, rhs);
                     end
                  end
               endcase
               if (ok) begin
                  calc_depth--;
                  calc_stack[calc_depth-1] = res;
               end
            end
         end
         default: ;
      endcase
      // final token: report top and status, then clear
      if (lst) begin
         outcome.value  = '0;
         outcome.status = calc_error;
         if (calc_depth == 0) begin
            if (outcome.status == ST_OK)
               outcome.status = ST_UNDER;
         end else begin
            outcome.value = calc_stack[calc_depth-1];
            if (outcome.status == ST_OK && calc_depth > 1)
               outcome.status = ST_LEFT;
         end
         predicted_results.insert(predicted_results.size(), outcome);
         calc_depth = 0;
         calc_error = ST_OK;
      end
   endtask

   // offer one token word, called at a falling edge, returns at a falling edge
   task automatic send_token(input cmd_type cmd, input logic [30:0] opnd, input logic lst);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid   <= 1'b1;
      req_ch.cmd     <= cmd;
      req_ch.operand <= opnd;
      req_ch.last    <= lst;
      do @(posedge clock); while (!req_ch.ready);
      evaluate_token(cmd, opnd, lst);
      tokens_sent++;
      @(negedge clock);
   endtask

   // sender pauses until every predicted result has been seen
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (predicted_results.size() != 0);
   endtask

   // operand mix: extremes, small values for divides, full range
   function automatic logic [30:0] pick_operand();
      case ($urandom_range(9)) inside
         0:       return '0;
         1:       return '1;
         [2:3]:   return 31'($urandom);
         [4:5]:   return 31'($urandom_range(1000));
         default: return 31'($urandom_range(9));
      endcase
   endfunction

   // one well-formed expression, tokens in right-to-left order
   task automatic send_expression(input int max_ops);
      int      ops_left, leaves_left, depth;
      cmd_type op;
      ops_left    = $urandom_range(max_ops);
      leaves_left = ops_left + 1;
      depth       = 0;
      while (leaves_left + ops_left > 0) begin
         if (depth >= 2 && ops_left > 0 && (leaves_left == 0 || $urandom_range(1) == 1)) begin
            op = cmd_type'($urandom_range(CMD_ADD, CMD_DIV));
            ops_left--;
            depth--;
            send_token(op, pick_operand(), (leaves_left + ops_left) == 0);
         end else begin
            leaves_left--;
            depth++;
            send_token(CMD_PUSH, pick_operand(), (leaves_left + ops_left) == 0);
         end
      end
   endtask

   // short burst of arbitrary tokens, may leave a partial stack behind
   task automatic send_noise();
      int n, i;
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++)
         send_token(cmd_type'($urandom_range(CMD_PUSH, CMD_SPARE7)), 31'($urandom),
                    $urandom_range(2) == 0);
   endtask

   // builds the most negative value on top of the stack
   task automatic push_most_negative();
      send_token(CMD_PUSH, 31'd1, 1'b0);
      send_token(CMD_PUSH, '1, 1'b0);
      send_token(CMD_PUSH, '0, 1'b0);
      send_token(CMD_SUB, '0, 1'b0);
      send_token(CMD_SUB, '0, 1'b0);
   endtask

   task automatic test_operand_extremes();
      send_token(CMD_PUSH, '0, 1'b1);
      send_token(CMD_PUSH, '1, 1'b1);
      send_token(CMD_PUSH, 31'h2AAA_AAAA, 1'b1);
      send_token(CMD_PUSH, 31'h5555_5555, 1'b1);
      wait_for_results();
   endtask

   task automatic test_each_operation();
      // wrap on add and multiply, negative result on subtract
      send_token(CMD_PUSH, '1, 1'b0);
      send_token(CMD_PUSH, '1, 1'b0);
      send_token(CMD_ADD, '0, 1'b1);
      send_token(CMD_PUSH, '1, 1'b0);
      send_token(CMD_PUSH, '0, 1'b0);
      send_token(CMD_SUB, '0, 1'b1);
      send_token(CMD_PUSH, '1, 1'b0);
      send_token(CMD_PUSH, '1, 1'b0);
      send_token(CMD_MUL, '0, 1'b1);
      // negative dividend, truncation toward zero
      send_token(CMD_PUSH, 31'd2, 1'b0);
      send_token(CMD_PUSH, 31'd7, 1'b0);
      send_token(CMD_PUSH, '0, 1'b0);
      send_token(CMD_SUB, '0, 1'b0);
      send_token(CMD_DIV, '0, 1'b1);
      // negative divisor
      send_token(CMD_PUSH, 31'd2, 1'b0);
      send_token(CMD_PUSH, '0, 1'b0);
      send_token(CMD_SUB, '0, 1'b0);
      send_token(CMD_PUSH, 31'd7, 1'b0);
      send_token(CMD_DIV, '0, 1'b1);
      wait_for_results();
   endtask

   task automatic test_divide_corners();
      // divide by zero keeps the stack
      send_token(CMD_PUSH, '0, 1'b0);
      send_token(CMD_PUSH, 31'd5, 1'b0);
      send_token(CMD_DIV, '0, 1'b1);
      // most negative over minus one
      send_token(CMD_PUSH, 31'd1, 1'b0);
      send_token(CMD_PUSH, '0, 1'b0);
      send_token(CMD_SUB, '0, 1'b0);
      push_most_negative();
      send_token(CMD_DIV, '0, 1'b1);
      wait_for_results();
   endtask

   task automatic test_short_stack();
      send_token(CMD_ADD, '0, 1'b1);
      send_token(CMD_PUSH, 31'd9, 1'b0);
      send_token(CMD_MUL, '0, 1'b1);
      send_token(CMD_DIV, '0, 1'b0);
      send_token(CMD_SPARE5, '1, 1'b1);
      wait_for_results();
   endtask

   task automatic test_unused_codes();
      send_token(CMD_PUSH, 31'd3, 1'b0);
      send_token(CMD_SPARE5, '1, 1'b0);
      send_token(CMD_PUSH, 31'd4, 1'b0);
      send_token(CMD_SPARE6, '1, 1'b0);
      send_token(CMD_SUB, '0, 1'b0);
      send_token(CMD_SPARE7, '1, 1'b1);
      send_token(CMD_SPARE6, '0, 1'b1);
      wait_for_results();
   endtask

   task automatic test_leftover_and_sticky();
      send_token(CMD_PUSH, 31'd1, 1'b0);
      send_token(CMD_PUSH, 31'd2, 1'b1);
      // divide by zero, then underflow: first error stays
      send_token(CMD_PUSH, '0, 1'b0);
      send_token(CMD_PUSH, 31'd8, 1'b0);
      send_token(CMD_DIV, '0, 1'b0);
      send_token(CMD_ADD, '0, 1'b0);
      send_token(CMD_ADD, '0, 1'b0);
      send_token(CMD_ADD, '0, 1'b1);
      wait_for_results();
   endtask

   task automatic test_stack_full();
      int i;
      for (i = 0; i < STACK_DEPTH; i++)
         send_token(CMD_PUSH, pick_operand(), 1'b0);
      send_token(CMD_PUSH, '1, 1'b0);
      send_token(CMD_ADD, '0, 1'b1);
      wait_for_results();
   endtask

   // receiver holds off while the sender keeps offering words
   task automatic test_output_hold_off();
      int i;
      hold_cycles = 300;
      for (i = 0; i < 20; i++)
         send_token(CMD_PUSH, pick_operand(), 1'b1);
      wait_for_results();
   endtask

   task automatic test_random_phase(input int unsigned pct_send, input int unsigned pct_recv,
                                    input int unsigned n_items);
      int unsigned stop_at;
      send_idle_pct  = pct_send;
      recv_stall_pct = pct_recv;
      stop_at        = tokens_sent + n_items;
      while (tokens_sent < stop_at) begin
         case ($urandom_range(9))
            0:       send_noise();
            1:       send_expression(20);
            default: send_expression(5);
         endcase
      end
      wait_for_results();
   endtask

   // receiver ready, with hold-off counted here
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin : check_results
      eval_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_checked++;
         if (predicted_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result: value %0d status %0d",
                        rsp_ch.value, rsp_ch.status);
         end else begin
            want = predicted_results.pop_front();
            if (rsp_ch.value !== want.value || rsp_ch.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch at result %0d: value exp %0d got %0d, status exp %0d got %0d",
                           results_checked, $signed(want.value), rsp_ch.value,
                           want.status, rsp_ch.status);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, predicted_results.size());
         $display("FAIL");
         $finish;
      end
   end

   // test sequence
   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.cmd     = CMD_PUSH;
      req_ch.operand = '0;
      req_ch.last    = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_operand_extremes();
      test_each_operation();
      test_divide_corners();
      test_short_stack();
      test_unused_codes();
      test_leftover_and_sticky();
      test_stack_full();
      test_output_hold_off();
      test_random_phase(0, 0, 165);
      test_random_phase(48, 0, 165);
      test_random_phase(0, 48, 165);
      test_random_phase(17, 17, 165);

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("sent %0d tokens, checked %0d results, %0d mismatches",
               tokens_sent, results_checked, mismatch_count);
      $display("covered all operations, wrap cases, short and full stack, divide by zero, "
               , "spare codes and output hold-off");
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
